/* rtl/core/ntpct_pkg.sv */
// ----------------------------------------------------------------------------
// NTP client tracking table package
// Shared types, operation codes and defaults for the client table block.
// ----------------------------------------------------------------------------
package ntpct_pkg;

  localparam int NUM_SLOTS_DEF      = 16;
  localparam logic [31:0] EXPIRY_WINDOW_RESET = 32'd4096;

  typedef enum logic [1:0] {
    OP_RECEIVE  = 2'd0,
    OP_TRANSMIT = 2'd1,
    OP_FIND     = 2'd2,
    OP_EXPIRE   = 2'd3
  } op_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port;
    logic [31:0] rx_seconds;
    logic [31:0] rx_fraction;
    logic [31:0] tx_seconds;
    logic [31:0] tx_fraction;
  } slot_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic start;
    logic eval;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stop;
    logic last;
    logic out_busy;
  } dp_status_t;

endpackage

/* rtl/core/ntpct_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ntpct_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ntpct_ctrl.sv */
// ----------------------------------------------------------------------------
// Client table controller
// Sequences accept, slot scan and result hand-off for one word at a time.
// ----------------------------------------------------------------------------
module ntpct_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ntpct_pkg::dp_status_t status,
  output ntpct_pkg::ctrl_cmd_t  cmd
);

  ntpct_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntpct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ntpct_pkg::ST_IDLE: begin
        if (in_valid) state_next = ntpct_pkg::ST_START;
      end
      ntpct_pkg::ST_START: begin
        state_next = ntpct_pkg::ST_SCAN;
      end
      ntpct_pkg::ST_SCAN: begin
        if (status.stop || status.last) state_next = ntpct_pkg::ST_FINISH;
      end
      ntpct_pkg::ST_FINISH: begin
        if (!status.out_busy) state_next = ntpct_pkg::ST_IDLE;
      end
      default: state_next = ntpct_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ntpct_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.load_req = in_valid;
      end
      ntpct_pkg::ST_START: begin
        cmd.start = 1'b1;
      end
      ntpct_pkg::ST_SCAN: begin
        cmd.eval = 1'b1;
      end
      ntpct_pkg::ST_FINISH: begin
        cmd.load_out = !status.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* rtl/core/ntpct_dp.sv */
// ----------------------------------------------------------------------------
// Client table datapath
// Slot RAM with valid bits, request latch, per-slot compare and result regs.
// ----------------------------------------------------------------------------
module ntpct_dp #(
  parameter int NUM_SLOTS = ntpct_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ntpct_pkg::ctrl_cmd_t  cmd,
  output ntpct_pkg::dp_status_t status,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata,
  input  logic [1:0]            operation,
  input  logic [63:0]           addr_high,
  input  logic [63:0]           addr_low,
  input  logic [15:0]           port,
  input  logic [31:0]           time_seconds,
  input  logic [31:0]           time_fraction,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  hit,
  output logic [3:0]            slot,
  output logic [15:0]           found_port,
  output logic [31:0]           found_rx_seconds,
  output logic [31:0]           found_rx_fraction,
  output logic [31:0]           found_tx_seconds,
  output logic [31:0]           found_tx_fraction,
  output logic [4:0]            expired_count
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam int ENTRY_W = $bits(ntpct_pkg::slot_entry_t);

  logic [31:0]            expiry_window;
  ntpct_pkg::op_t         req_op;
  logic [63:0]            req_addr_high;
  logic [63:0]            req_addr_low;
  logic [15:0]            req_port;
  logic [31:0]            req_seconds;
  logic [31:0]            req_fraction;

  logic [IDX_W-1:0]       cur_idx;
  logic [IDX_W-1:0]       rd_addr;
  logic [NUM_SLOTS-1:0]   valid;
  logic                   rd_valid;
  logic [ENTRY_W-1:0]     ram_q;
  ntpct_pkg::slot_entry_t entry;
  ntpct_pkg::slot_entry_t wr_entry;
  logic                   wr_en;

  logic                   hit_r;
  logic [IDX_W-1:0]       slot_r;
  ntpct_pkg::slot_entry_t found_r;
  logic [4:0]             count;

  logic                   addr_eq;
  logic                   empty;
  logic [31:0]            age;
  logic                   match;
  logic                   last;
  logic [IDX_W+3:0]       slot_ext;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      expiry_window <= ntpct_pkg::EXPIRY_WINDOW_RESET;
    end else if (cfg_we) begin
      expiry_window <= cfg_wdata;
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_op        <= ntpct_pkg::op_t'(operation);
      req_addr_high <= addr_high;
      req_addr_low  <= addr_low;
      req_port      <= port;
      req_seconds   <= time_seconds;
      req_fraction  <= time_fraction;
    end
  end

  assign last = (cur_idx == LAST_IDX);

  // read one slot ahead of the compare
  always_comb begin
    if (cmd.start || last) begin
      rd_addr = '0;
    end else begin
      rd_addr = cur_idx + 1'b1;
    end
  end

  ntpct_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (NUM_SLOTS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cur_idx),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // never-written slots read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (wr_en) valid[cur_idx] <= 1'b1;
    end
  end

  assign entry = rd_valid ? ntpct_pkg::slot_entry_t'(ram_q) : '0;

  assign addr_eq = (entry.addr_high == req_addr_high) && (entry.addr_low == req_addr_low);
  assign empty   = (entry.addr_high == 64'd0) && (entry.addr_low == 64'd0);
  assign age     = req_seconds - entry.rx_seconds;

  always_comb begin
    match    = 1'b0;
    wr_entry = entry;
    unique case (req_op)
      ntpct_pkg::OP_RECEIVE: begin
        match                = addr_eq || empty;
        wr_entry.addr_high   = req_addr_high;
        wr_entry.addr_low    = req_addr_low;
        wr_entry.port        = req_port;
        wr_entry.rx_seconds  = req_seconds;
        wr_entry.rx_fraction = req_fraction;
        wr_entry.tx_seconds  = '0;
        wr_entry.tx_fraction = '0;
      end
      ntpct_pkg::OP_TRANSMIT: begin
        match                = addr_eq && (entry.port == req_port);
        wr_entry.tx_seconds  = req_seconds;
        wr_entry.tx_fraction = req_fraction;
      end
      ntpct_pkg::OP_FIND: begin
        match = addr_eq && (entry.rx_seconds == req_seconds) &&
                (entry.rx_fraction == req_fraction);
      end
      ntpct_pkg::OP_EXPIRE: begin
        // keep the port, clear the rest
        match                = !empty && (age > expiry_window);
        wr_entry.addr_high   = '0;
        wr_entry.addr_low    = '0;
        wr_entry.rx_seconds  = '0;
        wr_entry.rx_fraction = '0;
        wr_entry.tx_seconds  = '0;
        wr_entry.tx_fraction = '0;
      end
      default: match = 1'b0;
    endcase
  end

  assign wr_en = cmd.eval && match && (req_op != ntpct_pkg::OP_FIND);

  assign status.stop     = match && (req_op != ntpct_pkg::OP_EXPIRE);
  assign status.last     = last;
  assign status.out_busy = out_valid && out_stall;

  // scan state
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_idx <= '0;
      hit_r   <= 1'b0;
      slot_r  <= '0;
      found_r <= '0;
      count   <= '0;
    end else if (cmd.eval) begin
      if (!last && !status.stop) cur_idx <= cur_idx + 1'b1;
      if (status.stop) begin
        hit_r  <= 1'b1;
        slot_r <= cur_idx;
        if (req_op == ntpct_pkg::OP_FIND) found_r <= entry;
      end
      if (match && (req_op == ntpct_pkg::OP_EXPIRE)) count <= count + 5'd1;
    end
  end

  assign slot_ext = {4'd0, slot_r};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      hit               <= hit_r;
      slot              <= slot_ext[3:0];
      found_port        <= found_r.port;
      found_rx_seconds  <= found_r.rx_seconds;
      found_rx_fraction <= found_r.rx_fraction;
      found_tx_seconds  <= found_r.tx_seconds;
      found_tx_fraction <= found_r.tx_fraction;
      expired_count     <= count;
    end
  end

endmodule

/* rtl/core/ntp_client_tracking_table_unit.sv */
// ----------------------------------------------------------------------------
// NTP client tracking table
// Keeps NUM_SLOTS client slots (address, port, rx and tx timestamps) and
// serves receive, transmit, find and expire requests.
//
// Usage:
// - Input channel: in_valid / in_stall with operation, address, port and
//   timestamp fields. A word is taken when in_valid is high and in_stall low.
// - Output channel: out_valid / out_stall with one result word per request.
//   The result register holds its word until out_stall drops.
// - Config: cfg_we / cfg_wdata write expiry_window; write it only while idle.
// - Scan: a request passes through start, one compare step per slot visited
//   and finish, walking the slot RAM one slot per cycle through its single
//   read port (NUM_SLOTS for receive/find/transmit misses and for every
//   expire); the next word can be accepted in the cycle after the result is
//   loaded.
// - A finished result may wait in the output register while the next word
//   is accepted and scanned; a new result is loaded only once the old one
//   has been taken.
// - Reset (rst, synchronous): all slots read empty, expiry_window returns to
//   4096 s, both channels go idle.
// ----------------------------------------------------------------------------
module ntp_client_tracking_table_unit #(
  parameter int NUM_SLOTS = ntpct_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic [15:0] port,
  input  logic [31:0] time_seconds,
  input  logic [31:0] time_fraction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic [3:0]  slot,
  output logic [15:0] found_port,
  output logic [31:0] found_rx_seconds,
  output logic [31:0] found_rx_fraction,
  output logic [31:0] found_tx_seconds,
  output logic [31:0] found_tx_fraction,
  output logic [4:0]  expired_count
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  ntpct_pkg::ctrl_cmd_t  cmd;
  ntpct_pkg::dp_status_t status;

  // sequence accept, scan and hand-off
  ntpct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // hold the table, compare one slot a cycle, drive the result word
  ntpct_dp #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .operation         (operation),
    .addr_high         (addr_high),
    .addr_low          (addr_low),
    .port              (port),
    .time_seconds      (time_seconds),
    .time_fraction     (time_fraction),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .hit               (hit),
    .slot              (slot),
    .found_port        (found_port),
    .found_rx_seconds  (found_rx_seconds),
    .found_rx_fraction (found_rx_fraction),
    .found_tx_seconds  (found_tx_seconds),
    .found_tx_fraction (found_tx_fraction),
    .expired_count     (expired_count)
  );

endmodule

/* sim/ntpct_reply_monitor.sv */
// ----------------------------------------------------------------------------
// NTP client table reply monitor
// Watches both channels of the client table block. Keeps its own slot table,
// works out the reply for every accepted request, and compares each accepted
// reply field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ntpct_reply_monitor #(
  parameter int NUM_SLOTS = ntpct_pkg::NUM_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [63:0] addr_high,
  input  logic [63:0] addr_low,
  input  logic [15:0] port,
  input  logic [31:0] time_seconds,
  input  logic [31:0] time_fraction,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        hit,
  input  logic [3:0]  slot,
  input  logic [15:0] found_port,
  input  logic [31:0] found_rx_seconds,
  input  logic [31:0] found_rx_fraction,
  input  logic [31:0] found_tx_seconds,
  input  logic [31:0] found_tx_fraction,
  input  logic [4:0]  expired_count,
  output int          mismatches,
  output int          pending,
  output int          replies_seen,
  output int          hits_seen,
  output int          slots_aged_out
);

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic [15:0] port;
    logic [31:0] rx_seconds;
    logic [31:0] rx_fraction;
    logic [31:0] tx_seconds;
    logic [31:0] tx_fraction;
    logic [4:0]  expired;
  } table_reply_t;

  table_reply_t awaited_replies[$];
  table_reply_t want;

  logic [63:0] tab_addr_hi [NUM_SLOTS];
  logic [63:0] tab_addr_lo [NUM_SLOTS];
  logic [15:0] tab_port    [NUM_SLOTS];
  logic [31:0] tab_rx_sec  [NUM_SLOTS];
  logic [31:0] tab_rx_frac [NUM_SLOTS];
  logic [31:0] tab_tx_sec  [NUM_SLOTS];
  logic [31:0] tab_tx_frac [NUM_SLOTS];
  logic [31:0] window;

  initial begin
    mismatches     = 0;
    replies_seen   = 0;
    hits_seen      = 0;
    slots_aged_out = 0;
  end

  // Apply one request to the local slot table and return the reply it yields.
  function automatic table_reply_t slot_table_apply(ntpct_pkg::op_t op, logic [63:0] hi,
                                                    logic [63:0] lo, logic [15:0] prt,
                                                    logic [31:0] secs, logic [31:0] frac);
    table_reply_t r;
    logic [31:0]  age;
    logic         used;
    int           count;
    bit           done;
    r     = '0;
    count = 0;
    done  = 0;
    case (op)
      ntpct_pkg::OP_RECEIVE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          used = (tab_addr_hi[i] != '0) || (tab_addr_lo[i] != '0);
          if (!done && ((tab_addr_hi[i] == hi && tab_addr_lo[i] == lo) || !used)) begin
            tab_addr_hi[i] = hi;
            tab_addr_lo[i] = lo;
            tab_port[i]    = prt;
            tab_rx_sec[i]  = secs;
            tab_rx_frac[i] = frac;
            tab_tx_sec[i]  = '0;
            tab_tx_frac[i] = '0;
            r.hit  = 1'b1;
            r.slot = 4'(i);
            done   = 1;
          end
        end
      end
      ntpct_pkg::OP_TRANSMIT: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!done && tab_addr_hi[i] == hi && tab_addr_lo[i] == lo && tab_port[i] == prt) begin
            tab_tx_sec[i]  = secs;
            tab_tx_frac[i] = frac;
            r.hit  = 1'b1;
            r.slot = 4'(i);
            done   = 1;
          end
        end
      end
      ntpct_pkg::OP_FIND: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!done && tab_addr_hi[i] == hi && tab_addr_lo[i] == lo &&
              tab_rx_sec[i] == secs && tab_rx_frac[i] == frac) begin
            r.hit         = 1'b1;
            r.slot        = 4'(i);
            r.port        = tab_port[i];
            r.rx_seconds  = tab_rx_sec[i];
            r.rx_fraction = tab_rx_frac[i];
            r.tx_seconds  = tab_tx_sec[i];
            r.tx_fraction = tab_tx_frac[i];
            done          = 1;
          end
        end
      end
      ntpct_pkg::OP_EXPIRE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          used = (tab_addr_hi[i] != '0) || (tab_addr_lo[i] != '0);
          age  = secs - tab_rx_sec[i];
          // the port survives a sweep, everything else goes
          if (used && age > window) begin
            tab_addr_hi[i] = '0;
            tab_addr_lo[i] = '0;
            tab_rx_sec[i]  = '0;
            tab_rx_frac[i] = '0;
            tab_tx_sec[i]  = '0;
            tab_tx_frac[i] = '0;
            count++;
          end
        end
        r.expired = 5'(count);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches = mismatches + 1;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val)
      flag_mismatch($sformatf("reply %0d %s: got %0h, want %0h", replies_seen, name, got,
                              exp_val));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tab_addr_hi[i] = '0;
        tab_addr_lo[i] = '0;
        tab_port[i]    = '0;
        tab_rx_sec[i]  = '0;
        tab_rx_frac[i] = '0;
        tab_tx_sec[i]  = '0;
        tab_tx_frac[i] = '0;
      end
      window = ntpct_pkg::EXPIRY_WINDOW_RESET;
      awaited_replies.delete();
    end else begin
      if (cfg_we) window = cfg_wdata;
      if (in_valid === 1'b1 && in_stall === 1'b0)
        awaited_replies.push_back(slot_table_apply(ntpct_pkg::op_t'(operation), addr_high,
                                                   addr_low, port, time_seconds,
                                                   time_fraction));
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (awaited_replies.size() == 0) begin
          flag_mismatch($sformatf("reply word with no request outstanding"));
        end else begin
          want = awaited_replies.pop_front();
          check_field("hit", hit, want.hit);
          check_field("slot", slot, want.slot);
          check_field("found_port", found_port, want.port);
          check_field("found_rx_seconds", found_rx_seconds, want.rx_seconds);
          check_field("found_rx_fraction", found_rx_fraction, want.rx_fraction);
          check_field("found_tx_seconds", found_tx_seconds, want.tx_seconds);
          check_field("found_tx_fraction", found_tx_fraction, want.tx_fraction);
          check_field("expired_count", expired_count, want.expired);
          hits_seen      = hits_seen + int'(want.hit);
          slots_aged_out = slots_aged_out + int'(want.expired);
        end
        replies_seen = replies_seen + 1;
      end
    end
    pending <= awaited_replies.size();
  end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// NTP client table testbench
// Drives receive, transmit, find and expire requests into the client table
// block with random gaps on the input and back-pressure on the output, across several
// expiry windows. A reply monitor beside the block checks every reply word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int NUM_SLOTS        = ntpct_pkg::NUM_SLOTS_DEF;
  localparam int POOL_SIZE        = 24;   // more clients than slots, so the table fills
  localparam int RANDOM_PHASES    = 6;
  localparam int PHASE_ITEMS      = 140;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT       = 2000;
  localparam int DRAIN_CYCLES     = NUM_SLOTS + 8;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  operation;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [15:0] port;
  logic [31:0] time_seconds;
  logic [31:0] time_fraction;
  logic        out_valid;
  logic        out_stall;
  logic        hit;
  logic [3:0]  slot;
  logic [15:0] found_port;
  logic [31:0] found_rx_seconds;
  logic [31:0] found_rx_fraction;
  logic [31:0] found_tx_seconds;
  logic [31:0] found_tx_fraction;
  logic [4:0]  expired_count;

  int mismatches;
  int pending;
  int replies_seen;
  int hits_seen;
  int slots_aged_out;

  // Stimulus bookkeeping: the client pool and the last rx stamp sent per client,
  // so that transmit and find mostly name something that is really in the table.
  logic [63:0] pool_hi     [POOL_SIZE];
  logic [63:0] pool_lo     [POOL_SIZE];
  logic [15:0] pool_port   [POOL_SIZE];
  logic [31:0] pool_rx_sec [POOL_SIZE];
  logic [31:0] pool_rx_frac[POOL_SIZE];
  logic [31:0] now;

  bit tx_steady = 0;   // sender offers back to back
  bit rx_steady = 0;   // receiver never stalls
  bit long_hold = 0;   // ask the receiver for one long stall
  int requests_sent = 0;
  int windows_used  = 0;
  int idle_cycles   = 0;

  ntp_client_tracking_table_unit #(
    .NUM_SLOTS(NUM_SLOTS)
  ) uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .addr_high        (addr_high),
    .addr_low         (addr_low),
    .port             (port),
    .time_seconds     (time_seconds),
    .time_fraction    (time_fraction),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hit              (hit),
    .slot             (slot),
    .found_port       (found_port),
    .found_rx_seconds (found_rx_seconds),
    .found_rx_fraction(found_rx_fraction),
    .found_tx_seconds (found_tx_seconds),
    .found_tx_fraction(found_tx_fraction),
    .expired_count    (expired_count)
  );

  ntpct_reply_monitor #(
    .NUM_SLOTS(NUM_SLOTS)
  ) reply_mon (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .addr_high        (addr_high),
    .addr_low         (addr_low),
    .port             (port),
    .time_seconds     (time_seconds),
    .time_fraction    (time_fraction),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .hit              (hit),
    .slot             (slot),
    .found_port       (found_port),
    .found_rx_seconds (found_rx_seconds),
    .found_rx_fraction(found_rx_fraction),
    .found_tx_seconds (found_tx_seconds),
    .found_tx_fraction(found_tx_fraction),
    .expired_count    (expired_count),
    .mismatches       (mismatches),
    .pending          (pending),
    .replies_seen     (replies_seen),
    .hits_seen        (hits_seen),
    .slots_aged_out   (slots_aged_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  // The long receiver hold is the longest legal quiet stretch, well under the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d replies outstanding",
                 IDLE_LIMIT, pending);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Receiver: draw a stall length per reply word, then take the word.
  // On request, hold off for a long stretch so the block backs up into its input.
  initial begin : receiver
    int wait_n;
    out_stall = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 0;
        out_stall <= 1'b0;
      end else begin
        wait_n = rx_steady ? 0 : $urandom_range(0, 9);
        if (wait_n > 0) begin
          out_stall <= 1'b1;
          repeat (wait_n) @(negedge clk);
        end
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Offer one request word after a random gap and hold it until it is taken.
  task automatic send_request(input ntpct_pkg::op_t op, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [15:0] prt,
                              input logic [31:0] secs, input logic [31:0] frac);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation     <= op;
    addr_high     <= hi;
    addr_low      <= lo;
    port          <= prt;
    time_seconds  <= secs;
    time_fraction <= frac;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    requests_sent++;
  endtask

  // Drop valid and hold until every reply word has come back.
  task automatic wait_all_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_window(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    windows_used++;
  endtask

  // One random request: mostly well-formed traffic from the client pool, some noise.
  task automatic random_request();
    int          k;
    int          pick;
    logic [15:0] prt;
    logic [31:0] secs;
    logic [31:0] frac;
    k    = $urandom_range(0, POOL_SIZE - 1);
    pick = $urandom_range(0, 99);
    prt  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : pool_port[k];
    if (pick < 35) begin
      now  = now + $urandom_range(0, 40);
      frac = $urandom;
      pool_rx_sec[k]  = now;
      pool_rx_frac[k] = frac;
      send_request(ntpct_pkg::OP_RECEIVE, pool_hi[k], pool_lo[k], prt, now, frac);
    end else if (pick < 60) begin
      send_request(ntpct_pkg::OP_TRANSMIT, pool_hi[k], pool_lo[k], prt, $urandom, $urandom);
    end else if (pick < 85) begin
      if ($urandom_range(0, 4) == 0)
        send_request(ntpct_pkg::OP_FIND, pool_hi[k], pool_lo[k], 16'($urandom), $urandom,
                     $urandom);
      else
        send_request(ntpct_pkg::OP_FIND, pool_hi[k], pool_lo[k], 16'($urandom),
                     pool_rx_sec[k], pool_rx_frac[k]);
    end else if (pick < 95) begin
      case ($urandom_range(0, 3))
        0:       secs = now;
        1:       secs = now + $urandom_range(0, 8192);
        2:       secs = $urandom;
        default: secs = now - $urandom_range(0, 100);
      endcase
      send_request(ntpct_pkg::OP_EXPIRE, {$urandom, $urandom}, {$urandom, $urandom},
                   16'($urandom), secs, $urandom);
    end else begin
      send_request(ntpct_pkg::op_t'($urandom_range(0, 3)), {$urandom, $urandom},
                   {$urandom, $urandom}, 16'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin : stimulus
    logic [31:0] win;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    operation     = ntpct_pkg::OP_RECEIVE;
    addr_high     = '0;
    addr_low      = '0;
    port          = '0;
    time_seconds  = '0;
    time_fraction = '0;
    now           = 32'd1000;

    // Client pool: the all-zero and all-one addresses first, the rest random.
    for (int k = 0; k < POOL_SIZE; k++) begin
      pool_hi[k]      = {$urandom, $urandom};
      pool_lo[k]      = {$urandom, $urandom};
      pool_port[k]    = 16'($urandom);
      pool_rx_sec[k]  = '0;
      pool_rx_frac[k] = '0;
    end
    pool_hi[0]   = '0;
    pool_lo[0]   = '0;
    pool_port[0] = '0;
    pool_hi[1]   = '1;
    pool_lo[1]   = '1;
    pool_port[1] = '1;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed part, window at its reset value.
    // A zero address compares like any other, so find and transmit hit the empty slot 0.
    send_request(ntpct_pkg::OP_FIND, '0, '0, '0, '0, '0);
    send_request(ntpct_pkg::OP_TRANSMIT, '0, '0, '0, 32'd5, 32'd7);
    // extremes of every field
    send_request(ntpct_pkg::OP_RECEIVE, '1, '1, '1, '1, '1);
    send_request(ntpct_pkg::OP_RECEIVE, pool_hi[2], pool_lo[2], 16'd1, 32'd100,
                 32'h1234_5678);
    // same address again takes the same slot and clears its tx stamp
    send_request(ntpct_pkg::OP_RECEIVE, pool_hi[2], pool_lo[2], 16'd2, 32'd200,
                 32'h8765_4321);
    send_request(ntpct_pkg::OP_TRANSMIT, pool_hi[2], pool_lo[2], 16'd2, '1, '1);
    send_request(ntpct_pkg::OP_TRANSMIT, pool_hi[2], pool_lo[2], 16'd1, 32'd300, 32'd0);
    send_request(ntpct_pkg::OP_FIND, pool_hi[2], pool_lo[2], '0, 32'd200, 32'h8765_4321);
    send_request(ntpct_pkg::OP_FIND, pool_hi[2], pool_lo[2], '0, 32'd100, 32'h1234_5678);
    // fill the rest of the table, then one more client finds no slot
    for (int k = 3; k <= 17; k++)
      send_request(ntpct_pkg::OP_RECEIVE, pool_hi[k], pool_lo[k], pool_port[k], 32'd300 + k,
                   $urandom);
    // a sweep far ahead clears every slot at once
    send_request(ntpct_pkg::OP_EXPIRE, '0, '0, '0, 32'h8000_0000, '1);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      // pause the sender until the block has answered everything, then retune
      wait_all_replies();
      case (ph)
        0:       win = '0;
        1:       win = '1;
        2:       win = ntpct_pkg::EXPIRY_WINDOW_RESET;
        3:       win = 32'd1;
        4:       win = $urandom;
        default: win = $urandom_range(100, 20000);
      endcase
      write_window(win);
      tx_steady = (ph == 1) || (ph == 4);
      rx_steady = (ph == 3) || (ph == 4);
      // push the time base up to the 32-bit wrap in one phase
      if (ph == 3) now = 32'hFFFF_FF00;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 40) long_hold = 1;
        random_request();
      end
    end

    wait_all_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests over %0d expiry windows; checked %0d replies, %0d hits,",
             requests_sent, windows_used, replies_seen, hits_seen);
    $display("%0d slots aged out by sweeps, %0d mismatches.", slots_aged_out, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
